// ----- hdl/adte_pkg.sv -----
// Shared types, constants and helpers for the ASCII date to epoch seconds unit.
// No dependencies; imported by adte_front, the top level and the testbench.
`default_nettype none

package adte_pkg;

    // Stream payload and field widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 40;
    localparam int CYEAR_W     = 14;
    localparam int YEAR_W      = 15;
    localparam int CEN_W       = 8;
    localparam int REM_W       = 7;
    localparam int DAYS_W      = 23;
    localparam int HMS_W       = 17;
    localparam int SECS_W      = 38;

    // Reset value of the current year and its split into century and remainder
    localparam logic [CEN_W-1:0] CEN_RESET = 8'd20;
    localparam logic [REM_W-1:0] REM_RESET = 7'd0;

    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for all x below 16400
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 15'd1970;
    localparam logic [12:0]       LEAPS_TO_1969 = 13'd477;

    // Date length codes
    typedef enum logic [1:0] {
        LEN_6 = 2'd0,
        LEN_7 = 2'd1,
        LEN_8 = 2'd2
    } len_code_t;

    // Decoded fields leaving the front end
    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [5:0]        day;
        logic [4:0]        hour;
        logic [5:0]        mins;
        logic [5:0]        secs;
    } front_t;

    // Days in the year before the first of the given month (non-leap)
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Divide a value below 16400 by 100
    function automatic logic [CEN_W-1:0] div100(input logic [YEAR_W-1:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(DIV100_MUL);
        return CEN_W'(p >> DIV100_SHIFT);
    endfunction

    // ASCII decimal digit test
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/adte_front.sv -----
// Front end of the date converter: character check, digit decode, field
// range checks and year assembly over two register stages. Uses adte_pkg.
`default_nettype none

module adte_front
    import adte_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [63:0]      date_chars,
    input  wire logic [3:0]       date_length,
    input  wire logic [47:0]      time_chars,
    input  wire logic [CEN_W-1:0] cen,
    input  wire logic [REM_W-1:0] rem,
    output front_t                fr
);

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_ok_next, s1_ok_reg;
    logic [31:0] s1_dnib_next, s1_dnib_reg;
    logic [23:0] s1_tnib_next, s1_tnib_reg;
    len_code_t   s1_len_next, s1_len_reg;

    front_t      s2_reg, s2_next;
    logic        s2_valid_reg;

    // Stage 1: check characters and keep the low nibble of each byte
    always_comb
    begin
        logic len_ok;
        logic dig_ok;
        len_ok = (date_length >= 4'd6) && (date_length <= 4'd8);
        dig_ok = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            dig_ok = dig_ok && is_digit(date_chars[8*i +: 8])
                            && is_digit(time_chars[8*i +: 8]);
        end
        if (date_length >= 4'd7)
        begin
            dig_ok = dig_ok && is_digit(date_chars[55:48]);
        end
        if (date_length >= 4'd8)
        begin
            dig_ok = dig_ok && is_digit(date_chars[63:56]);
        end
        for (int i = 0; i < 8; i++)
        begin
            s1_dnib_next[4*i +: 4] = date_chars[8*i +: 4];
        end
        for (int i = 0; i < 6; i++)
        begin
            s1_tnib_next[4*i +: 4] = time_chars[8*i +: 4];
        end
        case (date_length)
            4'd7:    s1_len_next = LEN_7;
            4'd8:    s1_len_next = LEN_8;
            default: s1_len_next = LEN_6;
        endcase
        s1_ok_next    = len_ok && dig_ok;
        s1_valid_next = in_valid;
    end

    // Stage 2: build the numeric fields, check ranges, fold hour 24
    always_comb
    begin
        logic [7:0]        yy;
        logic [7:0]        mon;
        logic [7:0]        dy;
        logic [7:0]        hr;
        logic [7:0]        mi;
        logic [7:0]        se;
        logic [CEN_W-1:0]  cen_use;
        logic [YEAR_W-1:0] year;
        logic              range_ok;
        yy  = 8'(s1_dnib_reg[23:20]) * 8'd10 + 8'(s1_dnib_reg[19:16]);
        mon = 8'(s1_dnib_reg[15:12]) * 8'd10 + 8'(s1_dnib_reg[11:8]);
        dy  = 8'(s1_dnib_reg[7:4])   * 8'd10 + 8'(s1_dnib_reg[3:0]);
        hr  = 8'(s1_tnib_reg[23:20]) * 8'd10 + 8'(s1_tnib_reg[19:16]);
        mi  = 8'(s1_tnib_reg[15:12]) * 8'd10 + 8'(s1_tnib_reg[11:8]);
        se  = 8'(s1_tnib_reg[7:4])   * 8'd10 + 8'(s1_tnib_reg[3:0]);

        // Two-digit year falls back one century when ahead of the current year
        cen_use = cen;
        if ((yy > 8'(rem)) && (cen != '0))
        begin
            cen_use = cen - CEN_W'(1);
        end
        case (s1_len_reg)
            LEN_7:
            begin
                year = 15'd1900 + 15'(s1_dnib_reg[27:24]) * 15'd100 + 15'(yy);
            end
            LEN_8:
            begin
                year = 15'(s1_dnib_reg[31:28]) * 15'd1000
                     + 15'(s1_dnib_reg[27:24]) * 15'd100 + 15'(yy);
            end
            default:
            begin
                year = 15'(cen_use) * 15'd100 + 15'(yy);
            end
        endcase

        range_ok = (mon >= 8'd1) && (mon <= 8'd12) && (dy >= 8'd1) && (dy <= 8'd31)
                && (mi <= 8'd59) && (se <= 8'd59) && (hr <= 8'd24);

        s2_next.valid = s1_valid_reg;
        s2_next.ok    = s1_ok_reg && range_ok;
        s2_next.year  = year;
        s2_next.month = mon[3:0];
        s2_next.mins  = mi[5:0];
        s2_next.secs  = se[5:0];
        if (hr == 8'd24)
        begin
            s2_next.hour = 5'd0;
            s2_next.day  = dy[5:0] + 6'd1;
        end
        else
        begin
            s2_next.hour = hr[4:0];
            s2_next.day  = dy[5:0];
        end
    end

    // Advance both stages together when the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_dnib_reg  <= s1_dnib_next;
            s1_tnib_reg  <= s1_tnib_next;
            s1_len_reg   <= s1_len_next;
            s2_reg       <= s2_next;
        end
    end

    // Present the stage 2 fields with the reset valid bit
    always_comb
    begin
        fr       = s2_reg;
        fr.valid = s2_valid_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/ascii_date_to_epoch_seconds_unit.sv -----
// Top level of the ASCII date to epoch seconds converter: config register,
// day count and seconds stages. Uses adte_pkg and adte_front.
//
// Usage:
//   Requests enter on the s_ channel: s_tdata holds date_chars [63:0],
//   date_length [67:64], time_chars [115:68], zeros above. Results leave on
//   the m_ channel: m_tdata holds epoch_seconds [37:0], zeros above; m_tuser
//   holds date_valid. An invalid date gives epoch_seconds of zero.
//   cfg_we with cfg_wdata sets the current year used for two-digit years;
//   write it only while no request is in flight.
// Pipeline and throughput:
//   Six register stages: two in adte_front, then stages 3, 4 and 5, then the
//   output register. One request per cycle is taken while m_ is not stalled;
//   the stages hold the digit decode, divide by 100 via reciprocal, leap
//   count, days times 86400 and final add.
// Reset:
//   Clears all stage valid bits and sets the current year to 2000.
// Stall:
//   While m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready is low; nothing is dropped or repeated.
`default_nettype none

module ascii_date_to_epoch_seconds_unit
    import adte_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration
    input  wire logic                   cfg_we,
    input  wire logic [CYEAR_W-1:0]     cfg_wdata,     // current_year
    // Request stream
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,       // date_chars, date_length, time_chars
    // Result stream
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata,       // epoch_seconds
    output      logic [0:0]             m_tuser        // date_valid
);

    logic en;

    // Current year, kept as century and remainder
    logic [CEN_W-1:0] cen_reg, cen_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    front_t fr;

    // Stage 3 registers
    logic              v3_reg;
    logic              ok3_reg, ok3_next;
    logic [YEAR_W-1:0] year3_reg;
    logic [CEN_W-1:0]  qy3_reg, qy3_next;
    logic [CEN_W-1:0]  qn3_reg, qn3_next;
    logic              gt3_reg, gt3_next;
    logic [13:0]       ydiff3_reg, ydiff3_next;
    logic [8:0]        mday3_reg, mday3_next;
    logic              mgt2_3_reg, mgt2_3_next;
    logic [HMS_W-1:0]  hms3_reg, hms3_next;

    // Stage 4 registers
    logic              v4_reg;
    logic              ok4_reg;
    logic [DAYS_W-1:0] days4_reg, days4_next;
    logic [HMS_W-1:0]  hms4_reg;

    // Stage 5 registers
    logic              v5_reg;
    logic              ok5_reg;
    logic [SECS_W-1:0] prod5_reg, prod5_next;
    logic [HMS_W-1:0]  hms5_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [SECS_W-1:0] out_secs_reg, out_secs_next;

    // Move every stage when the output is free or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Split a written year into century and remainder
    always_comb
    begin
        cen_next = div100(YEAR_W'(cfg_wdata));
        rem_next = REM_W'(YEAR_W'(cfg_wdata) - YEAR_W'(cen_next) * YEAR_W'(100));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg <= CEN_RESET;
            rem_reg <= REM_RESET;
        end
        else if (cfg_we)
        begin
            cen_reg <= cen_next;
            rem_reg <= rem_next;
        end
    end

    adte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .date_chars  (s_tdata[63:0]),
        .date_length (s_tdata[67:64]),
        .time_chars  (s_tdata[115:68]),
        .cen         (cen_reg),
        .rem         (rem_reg),
        .fr          (fr)
    );

    // Stage 3: quotients by 100, month offset, time of day in seconds
    always_comb
    begin
        logic [YEAR_W-1:0] ym1;
        ym1         = fr.year - YEAR_W'(1);
        ok3_next    = fr.ok;
        qy3_next    = div100(fr.year);
        qn3_next    = div100(ym1);
        gt3_next    = fr.year > EPOCH_YEAR;
        ydiff3_next = 14'(fr.year - EPOCH_YEAR);
        mday3_next  = days_before_month(fr.month) + 9'(fr.day) - 9'd1;
        mgt2_3_next = fr.month > 4'd2;
        hms3_next   = HMS_W'(fr.hour) * HMS_W'(3600) + HMS_W'(fr.mins) * HMS_W'(60)
                    + HMS_W'(fr.secs);
    end

    // Stage 4: whole-year days, leap day and days in the year
    always_comb
    begin
        logic [YEAR_W-1:0] ym1;
        logic [12:0]       leaps;
        logic              leap;
        logic [DAYS_W-1:0] ydays;
        ym1   = year3_reg - YEAR_W'(1);
        leaps = 13'(ym1 >> 2) - 13'(qn3_reg) + 13'(qn3_reg >> 2);
        leap  = (year3_reg[1:0] == 2'b00)
             && ((year3_reg != YEAR_W'(qy3_reg) * YEAR_W'(100)) || (qy3_reg[1:0] == 2'b00));
        ydays = '0;
        if (gt3_reg)
        begin
            ydays = DAYS_W'(ydiff3_reg) * DAYS_W'(365) + DAYS_W'(leaps)
                  - DAYS_W'(LEAPS_TO_1969);
        end
        days4_next = ydays + DAYS_W'(leap && mgt2_3_reg) + DAYS_W'(mday3_reg);
    end

    // Stage 5: days to seconds; stage 6: add time of day, zero on error
    always_comb
    begin
        logic [DAYS_W+HMS_W-1:0] p;
        p             = (DAYS_W+HMS_W)'(days4_reg) * (DAYS_W+HMS_W)'(86400);
        prod5_next    = p[SECS_W-1:0];
        out_secs_next = ok5_reg ? (prod5_reg + SECS_W'(hms5_reg)) : '0;
    end

    // Hold valid bits; advance on enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg        <= fr.valid;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok3_reg      <= ok3_next;
            year3_reg    <= fr.year;
            qy3_reg      <= qy3_next;
            qn3_reg      <= qn3_next;
            gt3_reg      <= gt3_next;
            ydiff3_reg   <= ydiff3_next;
            mday3_reg    <= mday3_next;
            mgt2_3_reg   <= mgt2_3_next;
            hms3_reg     <= hms3_next;
            ok4_reg      <= ok3_reg;
            days4_reg    <= days4_next;
            hms4_reg     <= hms3_reg;
            ok5_reg      <= ok4_reg;
            prod5_reg    <= prod5_next;
            hms5_reg     <= hms4_reg;
            out_ok_reg   <= ok5_reg;
            out_secs_reg <= out_secs_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-SECS_W)'(0), out_secs_reg};
    assign m_tuser  = out_ok_reg;

    // An error result carries zero seconds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[SECS_W-1:0] == '0))
        else $error("invalid result with nonzero seconds");

    // A request in the last stage reaches the output when the pipeline moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && v5_reg) |=> m_tvalid)
        else $error("result lost between last stage and output");

    // A front-end result that passed the checks has a month in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (fr.valid && fr.ok) |-> ((fr.month >= 4'd1) && (fr.month <= 4'd12)))
        else $error("accepted date with month out of range");

endmodule

`default_nettype wire

// ----- tb/ascii_date_to_epoch_seconds_unit_tb.sv -----
// Self-checking testbench for the ASCII date to epoch seconds unit: directed
// and random requests across several current-year settings and idling modes.
// Depends on adte_pkg and ascii_date_to_epoch_seconds_unit.
`default_nettype none

module ascii_date_to_epoch_seconds_unit_tb;
    import adte_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int PRESSURE_PHASE  = 4;

    // One request as carried in s_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [47:0] time_chars;
        logic [3:0]  date_length;
        logic [63:0] date_chars;
    } date_req_t;

    // One conversion result
    typedef struct packed {
        logic              date_valid;
        logic [SECS_W-1:0] epoch_seconds;
    } epoch_result_t;

    // Ways a random request is broken
    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_LENGTH,
        FLAW_DATE_CHAR,
        FLAW_TIME_CHAR,
        FLAW_MONTH,
        FLAW_DAY,
        FLAW_HOUR,
        FLAW_MINSEC,
        FLAW_RAW
    } flaw_t;

    class epoch_scoreboard;
        epoch_result_t      expected_epochs[$];
        logic [CYEAR_W-1:0] current_year = 14'd2000;
        int                 errors = 0;
        int unsigned        month_start[13] =
            '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

        function void set_year(input logic [CYEAR_W-1:0] y);
            current_year = y;
        endfunction

        function int pending();
            return expected_epochs.size();
        endfunction

        function bit leap_year(input longint unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function longint unsigned leap_count(input longint unsigned n);
            return n / 4 - n / 100 + n / 400;
        endfunction

        // Parse, range check and convert one request to seconds since 1970
        function epoch_result_t convert_date(input date_req_t r);
            epoch_result_t   res;
            int unsigned     d[8];
            int unsigned     t[6];
            int unsigned     len, o, yy, mon, dy, hr, mi, se, cen;
            longint unsigned yr, days, total;
            logic [7:0]      c;
            bit              ok;
            res = '0;
            yr  = 0;
            len = r.date_length;
            ok  = (len >= 6) && (len <= 8);
            for (int k = 0; k < 8; k++)
            begin
                if (ok && k < len)
                begin
                    c = r.date_chars[8*(len-1-k) +: 8];
                    if (c < 8'h30 || c > 8'h39)
                        ok = 0;
                    else
                        d[k] = c - 8'h30;
                end
            end
            for (int k = 0; k < 6; k++)
            begin
                if (ok)
                begin
                    c = r.time_chars[8*(5-k) +: 8];
                    if (c < 8'h30 || c > 8'h39)
                        ok = 0;
                    else
                        t[k] = c - 8'h30;
                end
            end
            if (ok)
            begin
                o   = len - 6;
                yy  = d[o] * 10 + d[o+1];
                mon = d[o+2] * 10 + d[o+3];
                dy  = d[o+4] * 10 + d[o+5];
                hr  = t[0] * 10 + t[1];
                mi  = t[2] * 10 + t[3];
                se  = t[4] * 10 + t[5];
                // Place a two-digit year in this century or the one before
                case (len)
                    6:
                    begin
                        cen = current_year / 100;
                        if (yy > current_year % 100 && cen > 0)
                            cen--;
                        yr = cen * 100 + yy;
                    end
                    7:       yr = 1900 + d[0] * 100 + yy;
                    default: yr = d[0] * 1000 + d[1] * 100 + yy;
                endcase
                if (mon < 1 || mon > 12 || dy < 1 || dy > 31 || mi > 59 || se > 59)
                    ok = 0;
                else if (hr == 24)
                begin
                    // Roll midnight into the next day, even past day 31
                    hr = 0;
                    dy++;
                end
                else if (hr > 23)
                    ok = 0;
            end
            if (ok)
            begin
                // Years before the epoch add no whole-year days
                days = 0;
                if (yr > 1970)
                    days = 365 * (yr - 1970) + leap_count(yr - 1) - leap_count(1969);
                if (leap_year(yr) && mon > 2)
                    days++;
                days  = days + month_start[mon] + dy - 1;
                total = ((days * 24 + hr) * 60 + mi) * 60 + se;
                res.date_valid    = 1'b1;
                res.epoch_seconds = total[SECS_W-1:0];
            end
            return res;
        endfunction

        function void note_request(input date_req_t r);
            expected_epochs.push_back(convert_date(r));
        endfunction

        function void check_result(input logic [SECS_W-1:0] seconds, input logic valid);
            epoch_result_t exp_res;
            if (expected_epochs.size() == 0)
            begin
                $error("result with nothing expected: epoch_seconds %0d date_valid %0d",
                       seconds, valid);
                errors++;
                return;
            end
            exp_res = expected_epochs.pop_front();
            if (seconds !== exp_res.epoch_seconds)
            begin
                $error("epoch_seconds mismatch: expected %0d, actual %0d",
                       exp_res.epoch_seconds, seconds);
                errors++;
            end
            if (valid !== exp_res.date_valid)
            begin
                $error("date_valid mismatch: expected %0d, actual %0d",
                       exp_res.date_valid, valid);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CYEAR_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;      // date_chars, date_length, time_chars
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // epoch_seconds
    logic [0:0]             m_tuser;           // date_valid

    epoch_scoreboard board = new;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    ascii_date_to_epoch_seconds_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check results and drive ready: random stalls, or a long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[SECS_W-1:0], m_tuser[0]);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ascii_date_to_epoch_seconds_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [7:0] non_digit();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 47))
                                           : 8'($urandom_range(58, 255));
    endfunction

    // Build a request from field values; unused date bytes get random junk
    function automatic date_req_t encode(input int unsigned len, input int unsigned yr,
                                         input int unsigned mon, input int unsigned dy,
                                         input int unsigned hr, input int unsigned mi,
                                         input int unsigned se);
        date_req_t       r;
        longint unsigned dv, tv;
        r.date_chars  = {$urandom(), $urandom()};
        r.date_length = 4'(len);
        r.time_chars  = '0;
        dv = (longint'(yr) * 100 + mon) * 100 + dy;
        tv = (longint'(hr) * 100 + mi) * 100 + se;
        for (int k = 0; k < 8; k++)
        begin
            if (k < len)
            begin
                r.date_chars[8*k +: 8] = 8'(48 + dv % 10);
                dv = dv / 10;
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            r.time_chars[8*k +: 8] = 8'(48 + tv % 10);
            tv = tv / 10;
        end
        return r;
    endfunction

    // Random well-formed request, optionally broken in one way
    function automatic date_req_t random_date(input flaw_t flaw);
        date_req_t   r;
        int unsigned len, yr, mon, dy, hr, mi, se, pos;
        len = $urandom_range(6, 8);
        case (len)
            6:       yr = $urandom_range(0, 99);
            7:       yr = $urandom_range(0, 999);
            default: yr = ($urandom_range(0, 1) != 0) ? $urandom_range(1950, 2150)
                                                      : $urandom_range(0, 9999);
        endcase
        mon = $urandom_range(1, 12);
        dy  = $urandom_range(1, 31);
        hr  = $urandom_range(0, 24);
        mi  = $urandom_range(0, 59);
        se  = $urandom_range(0, 59);
        case (flaw)
            FLAW_MONTH:  mon = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 99);
            FLAW_DAY:    dy = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(32, 99);
            FLAW_HOUR:   hr = $urandom_range(25, 99);
            FLAW_MINSEC:
            begin
                if ($urandom_range(0, 1) != 0)
                    mi = $urandom_range(60, 99);
                else
                    se = $urandom_range(60, 99);
            end
            default: ;
        endcase
        r = encode(len, yr, mon, dy, hr, mi, se);
        case (flaw)
            FLAW_LENGTH:
                r.date_length = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 5))
                                                            : 4'($urandom_range(9, 15));
            FLAW_DATE_CHAR:
            begin
                pos = $urandom_range(0, len - 1);
                r.date_chars[8*pos +: 8] = non_digit();
            end
            FLAW_TIME_CHAR:
            begin
                pos = $urandom_range(0, 5);
                r.time_chars[8*pos +: 8] = non_digit();
            end
            FLAW_RAW:
            begin
                r.date_chars  = {$urandom(), $urandom()};
                r.date_length = 4'($urandom_range(0, 15));
                r.time_chars  = 48'({$urandom(), $urandom()});
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input date_req_t r);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic write_year(input logic [CYEAR_W-1:0] y);
        cfg_wdata <= y;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_year(y);
    endtask

    task automatic wait_for_results();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        date_req_t   r;
        date_req_t   directed_q[$];
        int unsigned phase_year[PHASES];
        int          phase_src[PHASES];
        int          phase_sink[PHASES];

        phase_year = '{1970, 9999, 2024, 50, 16383, 2069, 1999, 2000};
        phase_src  = '{0, 46, 0, 10, 0, 46, 0, 10};
        phase_sink = '{0, 0, 46, 10, 0, 0, 46, 10};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, leap and epoch edges, midnight rollover
        directed_q.push_back(encode(8, 1970, 1, 1, 0, 0, 0));
        directed_q.push_back(encode(8, 9999, 12, 31, 23, 59, 59));
        directed_q.push_back(encode(8, 9999, 12, 31, 24, 0, 0));
        directed_q.push_back(encode(8, 0, 1, 1, 0, 0, 0));
        directed_q.push_back(encode(8, 2000, 2, 29, 12, 0, 0));
        directed_q.push_back(encode(8, 2000, 3, 1, 0, 0, 0));
        directed_q.push_back(encode(8, 1900, 3, 1, 0, 0, 0));
        directed_q.push_back(encode(8, 1969, 12, 31, 24, 0, 0));
        directed_q.push_back(encode(7, 70, 1, 1, 0, 0, 0));
        directed_q.push_back(encode(7, 999, 12, 31, 23, 59, 59));
        // Two-digit years at and above the current year's remainder
        directed_q.push_back(encode(6, 0, 1, 1, 0, 0, 0));
        directed_q.push_back(encode(6, 1, 6, 15, 12, 30, 30));
        r = encode(6, 99, 12, 31, 23, 59, 59);
        r.date_chars[63:48] = 16'hFFFF;
        directed_q.push_back(r);
        // Bad lengths, bad characters, fields out of range
        directed_q.push_back(encode(5, 2020, 5, 5, 5, 5, 5));
        directed_q.push_back(encode(9, 2020, 5, 5, 5, 5, 5));
        directed_q.push_back(encode(15, 2020, 5, 5, 5, 5, 5));
        r = encode(8, 2020, 5, 5, 5, 5, 5);
        r.date_chars[15:8] = 8'h3A;
        directed_q.push_back(r);
        r = encode(8, 2020, 5, 5, 5, 5, 5);
        r.time_chars[47:40] = 8'h2F;
        directed_q.push_back(r);
        directed_q.push_back(encode(8, 2020, 0, 5, 5, 5, 5));
        directed_q.push_back(encode(8, 2020, 13, 5, 5, 5, 5));
        directed_q.push_back(encode(8, 2020, 5, 0, 5, 5, 5));
        directed_q.push_back(encode(8, 2020, 5, 32, 5, 5, 5));
        directed_q.push_back(encode(8, 2020, 5, 5, 25, 5, 5));
        directed_q.push_back(encode(8, 2020, 5, 5, 5, 60, 5));
        directed_q.push_back(encode(8, 2020, 5, 5, 5, 5, 60));

        foreach (directed_q[i])
            send_request(directed_q[i]);
        s_tvalid <= 1'b0;
        wait_for_results();

        // Random phases, each with its own current year and idling mode
        for (int p = 0; p < PHASES; p++)
        begin
            write_year(CYEAR_W'(phase_year[p]));
            src_idle_pct   = phase_src[p];
            sink_stall_pct = phase_sink[p];
            if (p == PRESSURE_PHASE)
                hold_requests++;
            repeat (ITEMS_PER_PHASE)
                send_request(random_date(($urandom_range(0, 99) < 80) ? FLAW_NONE :
                    flaw_t'($urandom_range(int'(FLAW_LENGTH), int'(FLAW_RAW)))));
            s_tvalid <= 1'b0;
            wait_for_results();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("ascii_date_to_epoch_seconds_unit_tb passed");
        else
            $display("ascii_date_to_epoch_seconds_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/adte_pkg.sv
hdl/adte_front.sv
hdl/ascii_date_to_epoch_seconds_unit.sv
tb/ascii_date_to_epoch_seconds_unit_tb.sv
